// File: rtl/krt_pkg.sv
package krt_pkg;

    localparam int KRT_DEPTH = 64;

    localparam int MODE_W  = 3;
    localparam int KEY_W   = 16;
    localparam int VAL_W   = 16;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 6;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

    // per-cell write control
    typedef struct packed {
        logic load_key;
        logic load_val;
        logic shift;
    } cell_ctl_t;

endpackage

// File: rtl/krt_cell.sv
module krt_cell
    import krt_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic             in_use,
    input  logic [KEY_W-1:0] cmp_key,
    input  logic [KEY_W-1:0] wr_key,
    input  logic [VAL_W-1:0] wr_val,
    input  logic [KEY_W-1:0] nbr_key,
    input  logic [VAL_W-1:0] nbr_val,
    output logic [KEY_W-1:0] key,
    output logic [VAL_W-1:0] val,
    output logic             match
);

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic             match_reg;

    // shift takes the neighbor's entry, otherwise local writes
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            key_reg <= nbr_key;
            val_reg <= nbr_val;
        end
        else
        begin
            if (ctl.load_key)
            begin
                key_reg <= wr_key;
            end
            if (ctl.load_val)
            begin
                val_reg <= wr_val;
            end
        end
        match_reg <= in_use && (key_reg == cmp_key);
    end

    assign key   = key_reg;
    assign val   = val_reg;
    assign match = match_reg;

endmodule

// File: rtl/krt_select.sv
module krt_select
    import krt_pkg::*;
#(
    parameter int DEPTH = KRT_DEPTH,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic [DEPTH-1:0] match,
    input  logic [KEY_W-1:0] keys [DEPTH],
    input  logic [VAL_W-1:0] vals [DEPTH],
    output logic [DEPTH-1:0] onehot,
    output logic [DEPTH-1:0] at_or_above,
    output logic             found,
    output logic [IDX_W-1:0] slot,
    output logic [KEY_W-1:0] sel_key,
    output logic [VAL_W-1:0] sel_val
);

    logic [DEPTH-1:0] neg;
    logic [DEPTH-1:0] onehot_reg;
    logic [DEPTH-1:0] ge_reg;

    // lowest set bit and everything above it, from one negate
    assign neg = ~match + {{(DEPTH-1){1'b0}}, 1'b1};

    always_ff @(posedge clk)
    begin
        onehot_reg <= match & neg;
        ge_reg     <= match | neg;
    end

    always_comb
    begin
        slot    = '0;
        sel_key = '0;
        sel_val = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            if (onehot_reg[j])
            begin
                slot    = slot | IDX_W'(j);
                sel_key = sel_key | keys[j];
                sel_val = sel_val | vals[j];
            end
        end
    end

    assign onehot      = onehot_reg;
    assign at_or_above = ge_reg;
    assign found       = |onehot_reg;

endmodule

// File: rtl/keyed_record_table.sv
// keyed_record_table: packed table of up to DEPTH key/value entries held in a
// row of cells, one command per input item. Add appends at the tail (status
// full when DEPTH entries are held), search/update/delete act on the lowest
// slot whose key matches (duplicates allowed), and delete closes the gap by
// shifting every later cell down one place. Dump streams every entry in slot
// order with tlast on the final one, or a single empty status. Modes 5 to 7
// are consumed and produce nothing. Steps: a command other than dump passes
// through match (parallel key compare in every cell), pick (lowest match)
// and act, which loads its result in the output register, and the next item
// is taken once the block is back in idle; a dump goes from act to the dump
// state, which loads one entry per cycle while the output register is free,
// because the chain rotates one place per result so that cell 0 always
// presents the next entry, and after entry_count rotations the table is back
// in its original order. A new item is taken once the previous command has
// loaded its last result; that result may still be waiting in the output
// register. Stalls on m_tready pause the command in place.
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int DEPTH = KRT_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // mode[2:0], key[18:3], value[34:19], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // status[1:0], key_out[17:2], value_out[33:18],
                                            // slot[39:34]
    output logic                  m_tlast
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_ACT,
        ST_DUMP
    } state_t;

    state_t state_reg;

    // command registers
    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  dump_idx_reg;

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    // cell row
    cell_ctl_t        ctl      [DEPTH];
    logic [KEY_W-1:0] cell_key [DEPTH];
    logic [VAL_W-1:0] cell_val [DEPTH];
    logic [KEY_W-1:0] nbr_key  [DEPTH];
    logic [VAL_W-1:0] nbr_val  [DEPTH];
    logic [DEPTH-1:0] in_use;
    logic [DEPTH-1:0] match;

    // lowest-match pick
    logic [DEPTH-1:0] onehot;
    logic [DEPTH-1:0] at_or_above;
    logic             found;
    logic [IDX_W-1:0] sel_slot;
    logic [KEY_W-1:0] sel_key;
    logic [VAL_W-1:0] sel_val;

    logic out_free;
    logic accept;
    logic full;
    logic dump_last;
    logic act_go;
    logic dump_go;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign dump_last = ((dump_idx_reg + CNT_W'(1)) == count_reg);
    assign act_go    = (state_reg == ST_ACT) && out_free;
    assign dump_go   = (state_reg == ST_DUMP) && out_free;

    // each cell's neighbor is the next cell; the tail of the live region
    // (and the physical end of the row) wraps to cell 0 for dump rotation
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            assign in_use[g] = (CNT_W'(g) < count_reg);

            if (g == DEPTH - 1)
            begin : g_end
                assign nbr_key[g] = cell_key[0];
                assign nbr_val[g] = cell_val[0];
            end
            else
            begin : g_mid
                assign nbr_key[g] = (CNT_W'(g + 1) == count_reg) ? cell_key[0] : cell_key[g+1];
                assign nbr_val[g] = (CNT_W'(g + 1) == count_reg) ? cell_val[0] : cell_val[g+1];
            end

            krt_cell u_cell (
                .clk     (clk),
                .ctl     (ctl[g]),
                .in_use  (in_use[g]),
                .cmp_key (key_reg),
                .wr_key  (key_reg),
                .wr_val  (val_reg),
                .nbr_key (nbr_key[g]),
                .nbr_val (nbr_val[g]),
                .key     (cell_key[g]),
                .val     (cell_val[g]),
                .match   (match[g])
            );
        end
    endgenerate

    krt_select #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_select (
        .clk         (clk),
        .match       (match),
        .keys        (cell_key),
        .vals        (cell_val),
        .onehot      (onehot),
        .at_or_above (at_or_above),
        .found       (found),
        .slot        (sel_slot),
        .sel_key     (sel_key),
        .sel_val     (sel_val)
    );

    // cell write controls
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            ctl[j] = '0;
            if (act_go)
            begin
                case (mode_reg)
                    MODE_ADD:
                    begin
                        // append at the tail
                        ctl[j].load_key = !full && (CNT_W'(j) == count_reg);
                        ctl[j].load_val = !full && (CNT_W'(j) == count_reg);
                    end
                    MODE_UPDATE:
                    begin
                        ctl[j].load_val = onehot[j];
                    end
                    MODE_DELETE:
                    begin
                        // matched cell and all above take their neighbor
                        ctl[j].shift = at_or_above[j];
                    end
                    default:
                    begin
                        ctl[j] = '0;
                    end
                endcase
            end
            else if (dump_go)
            begin
                // rotate the live region by one place
                ctl[j].shift = in_use[j];
            end
        end
    end

    // control, command and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            mode_reg      <= '0;
            key_reg       <= '0;
            val_reg       <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= s_tdata[2:0];
                        key_reg  <= s_tdata[18:3];
                        val_reg  <= s_tdata[34:19];
                        // unused modes are dropped here
                        if (s_tdata[2:0] == MODE_ADD || s_tdata[2:0] == MODE_SEARCH ||
                            s_tdata[2:0] == MODE_UPDATE || s_tdata[2:0] == MODE_DELETE ||
                            s_tdata[2:0] == MODE_DUMP)
                        begin
                            state_reg <= ST_MATCH;
                        end
                    end
                end
                ST_MATCH:
                begin
                    state_reg <= ST_PICK;
                end
                ST_PICK:
                begin
                    state_reg <= ST_ACT;
                end
                ST_ACT:
                begin
                    if (out_free)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        out_last_reg  <= 1'b1;
                        case (mode_reg)
                            MODE_ADD:
                            begin
                                if (full)
                                begin
                                    out_data_reg <= {SLOT_W'(0), VAL_W'(0), KEY_W'(0), STAT_FULL};
                                end
                                else
                                begin
                                    out_data_reg <= {SLOT_W'(count_reg[IDX_W-1:0]), val_reg,
                                                     key_reg, STAT_OK};
                                    count_reg    <= count_reg + CNT_W'(1);
                                end
                            end
                            MODE_SEARCH, MODE_UPDATE, MODE_DELETE:
                            begin
                                if (!found)
                                begin
                                    out_data_reg <= {SLOT_W'(0), VAL_W'(0), KEY_W'(0),
                                                     STAT_NOT_FOUND};
                                end
                                else
                                begin
                                    out_data_reg <= {SLOT_W'(sel_slot),
                                                     (mode_reg == MODE_UPDATE) ? val_reg : sel_val,
                                                     sel_key, STAT_OK};
                                    if (mode_reg == MODE_DELETE)
                                    begin
                                        count_reg <= count_reg - CNT_W'(1);
                                    end
                                end
                            end
                            MODE_DUMP:
                            begin
                                if (count_reg == '0)
                                begin
                                    out_data_reg <= {SLOT_W'(0), VAL_W'(0), KEY_W'(0),
                                                     STAT_EMPTY};
                                end
                                else
                                begin
                                    // no result yet, entries stream from ST_DUMP
                                    out_valid_reg <= !m_tready && out_valid_reg;
                                    dump_idx_reg  <= '0;
                                    state_reg     <= ST_DUMP;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DUMP:
                begin
                    if (out_free)
                    begin
                        // cell 0 always holds the next entry in slot order
                        out_valid_reg <= 1'b1;
                        out_last_reg  <= dump_last;
                        out_data_reg  <= {SLOT_W'(dump_idx_reg[IDX_W-1:0]), cell_val[0],
                                          cell_key[0], STAT_OK};
                        dump_idx_reg  <= dump_idx_reg + CNT_W'(1);
                        if (dump_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(onehot))
        else $error("more than one lowest match picked");

    a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
        dump_go && dump_last |=> state_reg == ST_IDLE && m_tvalid && m_tlast)
        else $error("dump did not finish on its last entry");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        act_go && mode_reg == MODE_DELETE && found |=>
            count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not shrink the table");

    // unused modes are swallowed in idle, so only real commands leave it
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_tdata[2:0] <= MODE_DUMP) |=> !s_tready)
        else $error("second item taken before command processed");
`endif

endmodule
